FILE: hw/rtl/ppcx_pkg.sv
// shared types and constants for the integer execute unit
package ppcx_pkg;

  typedef enum logic [5:0] {
    OP_ADDC = 6'd0, OP_ADDE = 6'd1, OP_ADDI = 6'd2, OP_ADDIC = 6'd3, OP_ADDICR = 6'd4,
    OP_ADDIS = 6'd5, OP_ADDME = 6'd6, OP_ADD = 6'd7, OP_ADDZE = 6'd8, OP_ANDC = 6'd9,
    OP_ANDIR = 6'd10, OP_ANDISR = 6'd11, OP_AND = 6'd12, OP_CMP = 6'd13, OP_CMPI = 6'd14,
    OP_CMPL = 6'd15, OP_CMPLI = 6'd16, OP_CNTLZW = 6'd17, OP_DIVWU = 6'd18,
    OP_DIVW = 6'd19, OP_EQV = 6'd20, OP_EXTSB = 6'd21, OP_EXTSH = 6'd22,
    OP_MULHWU = 6'd23, OP_MULHW = 6'd24, OP_MULLI = 6'd25, OP_MULLW = 6'd26,
    OP_NAND = 6'd27, OP_NEG = 6'd28, OP_NOR = 6'd29, OP_ORC = 6'd30, OP_ORI = 6'd31,
    OP_ORIS = 6'd32, OP_OR = 6'd33, OP_RLWIMI = 6'd34, OP_RLWINM = 6'd35,
    OP_RLWNM = 6'd36, OP_SLW = 6'd37, OP_SRAWI = 6'd38, OP_SRAW = 6'd39,
    OP_SRW = 6'd40, OP_SUBFC = 6'd41, OP_SUBFE = 6'd42, OP_SUBFIC = 6'd43,
    OP_SUBFME = 6'd44, OP_SUBF = 6'd45, OP_SUBFZE = 6'd46, OP_TW = 6'd47,
    OP_TWI = 6'd48, OP_XORI = 6'd49, OP_XORIS = 6'd50, OP_XOR = 6'd51,
    OP_WRITE = 6'd52, OP_READ = 6'd53
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_TRAP = 2'd1, ST_OE_UNSUP = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_DONE
  } state_t;

  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [3:0] CR_LT = 4'b1000;
  localparam logic [3:0] CR_GT = 4'b0100;
  localparam logic [3:0] CR_EQ = 4'b0010;

  // one decoded item, carried from the front end to the execute logic
  typedef struct packed {
    logic [5:0]  func;
    logic [4:0]  dst_reg;
    logic [4:0]  src_a_reg;
    logic [31:0] immediate;
    logic [4:0]  shift_amount;
    logic [4:0]  mask_begin;
    logic [4:0]  mask_end;
    logic [4:0]  trap_cond;
    logic [2:0]  cr_index;
    logic        record;
    logic        overflow_enable;
  } item_t;

  // divider handshake
  typedef struct packed {
    logic        go;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  // rotate mask, bit 0 most significant, wrapping when end is below begin
  function automatic logic [31:0] rot_mask(input logic [4:0] mb, input logic [4:0] me);
    logic [31:0] b;
    logic [31:0] e;
    logic [31:0] m;
    begin
      b = ALL_ONES >> mb;
      e = (me == 5'd31) ? 32'd0 : (ALL_ONES >> (6'(me) + 6'd1));
      m = b ^ e;
      rot_mask = (me < mb) ? ~m : m;
    end
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] d;
    begin
      d = {v, v} << n;
      rotl = d[63:32];
    end
  endfunction

  function automatic logic [5:0] clz(input logic [31:0] v);
    logic [5:0] n;
    logic       hit;
    begin
      n = 6'd32;
      hit = 1'b0;
      for (int i = 31; i >= 0; i--) begin
        if (v[i] && !hit) begin
          n = 6'(31 - i);
          hit = 1'b1;
        end
      end
      clz = n;
    end
  endfunction

endpackage

FILE: hw/rtl/ppcx_regfile.sv
// 32 x 32 register file: one synchronous memory, two read ports, written bits and write forwarding
module ppcx_regfile (
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  raddr_a,
  input  logic [4:0]  raddr_b,
  output logic [31:0] rdata_a,
  output logic [31:0] rdata_b,
  input  logic        we,
  input  logic [4:0]  waddr,
  input  logic [31:0] wdata
);

  logic [31:0] mem [32];
  logic [31:0] valid;
  logic [31:0] qa;
  logic [31:0] qb;
  logic        va;
  logic        vb;

  // memory write and registered reads; a read of the entry being written sees the new data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    qa <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
    qb <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
  end

  // entries never written read as zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      va <= valid[raddr_a] || (we && waddr == raddr_a);
      vb <= valid[raddr_b] || (we && waddr == raddr_b);
    end
  end

  assign rdata_a = va ? qa : '0;
  assign rdata_b = vb ? qb : '0;

endmodule

FILE: hw/rtl/ppcx_divider.sv
// unsigned radix-2 restoring divider, one quotient bit per cycle
module ppcx_divider (
  input  logic               clk,
  input  logic               rst,
  input  ppcx_pkg::div_req_t req,
  output ppcx_pkg::div_rsp_t rsp
);

  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic        done_q;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dsr};

  // shift-subtract loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt <= 6'd32;
        quo <= req.dividend;
        rem <= '0;
        dsr <= req.divisor;
      end else if (busy) begin
        if (trial[32]) begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end else begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done_q, quotient: quo};

endmodule

FILE: hw/rtl/ppc32_integer_execute_unit.sv
// top level of the 32-bit integer execute unit
//
// Command channel: an item is taken on a rising edge with start high and busy low.
// busy rises on the next cycle and stays up until the result strobe.
// Each item reads its operands from the register-file memory (a registered
// read), executes, and drives the result ports for one cycle with done high;
// the receiver cannot hold a result off.
// Sequence from acceptance to done: READ, EXEC, then DONE for most operations,
// with a MUL state for the multiplies (registered product) and a DIV state for
// divides (one quotient bit per cycle in the shared divider). The next item may be
// started in the cycle done is high, so items are taken one at a time.
// Configuration: APB port, register 0 at byte address 0 is summary_overflow;
// pready is always high; the user writes only while the unit is idle (not enforced).
// Reset clears the register file (a written-bit per entry), the carry flag,
// summary_overflow and all control state; it is synchronous to the rising clock edge.
module ppc32_integer_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  func,
  input  logic [4:0]  dst_reg,
  input  logic [4:0]  src_a_reg,
  input  logic [4:0]  src_b_reg,
  input  logic [31:0] immediate,
  input  logic [4:0]  shift_amount,
  input  logic [4:0]  mask_begin,
  input  logic [4:0]  mask_end,
  input  logic [4:0]  trap_cond,
  input  logic [2:0]  cr_index,
  input  logic        record,
  input  logic        overflow_enable,
  output logic        done,
  output logic [4:0]  dest_index,
  output logic [31:0] result_value,
  output logic        result_written,
  output logic [2:0]  cr_field,
  output logic [3:0]  cr_value,
  output logic        cr_written,
  output logic        carry_out,
  output logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ppcx_pkg::state_t state;
  ppcx_pkg::state_t state_next;
  ppcx_pkg::item_t  it;
  ppcx_pkg::div_req_t dreq;
  ppcx_pkg::div_rsp_t drsp;

  logic        summary_overflow;
  logic        carry_flag;
  logic [4:0]  rd_a;
  logic [4:0]  rd_b;
  logic [31:0] ra;
  logic [31:0] rb;
  logic [31:0] ra_q;
  logic [31:0] rb_q;
  logic [31:0] rdo_q;
  logic        we;
  logic [31:0] wdata;
  logic [63:0] prod;
  logic        div_op;
  logic        mul_op;
  logic        accept;

  // decoded result of the execute step
  logic [31:0] val;
  logic        nca;
  logic        wr;
  logic        rec;
  logic        cmpw;
  logic        rdv;
  logic        oechk;
  logic        trap;
  logic [3:0]  crv;

  assign accept = start && !busy;
  assign pready = 1'b1;
  assign prdata = {31'd0, summary_overflow};

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      summary_overflow <= 1'b0;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      summary_overflow <= pwdata[0];
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      it <= '{func, dst_reg, src_a_reg, immediate, shift_amount, mask_begin, mask_end,
              trap_cond, cr_index, record, overflow_enable};
    end
  end

  // register file: port b reads the destination in a second read cycle for rlwimi/read
  assign rd_a = accept ? src_a_reg : it.src_a_reg;
  assign rd_b = accept ? src_b_reg : it.dst_reg;

  ppcx_regfile u_rf (
    .clk(clk), .rst(rst), .raddr_a(rd_a), .raddr_b(rd_b),
    .rdata_a(ra), .rdata_b(rb), .we(we), .waddr(it.dst_reg), .wdata(wdata)
  );

  // operand registers: a and b in READ, old destination value arrives in EXEC
  always_ff @(posedge clk) begin
    if (state == ppcx_pkg::S_READ) begin
      ra_q <= ra;
      rb_q <= rb;
    end
  end
  always_ff @(posedge clk) begin
    if (state == ppcx_pkg::S_EXEC) begin
      rdo_q <= rb;
    end
  end

  assign mul_op = it.func == ppcx_pkg::OP_MULHWU || it.func == ppcx_pkg::OP_MULHW ||
                  it.func == ppcx_pkg::OP_MULLI || it.func == ppcx_pkg::OP_MULLW;
  assign div_op = it.func == ppcx_pkg::OP_DIVWU || it.func == ppcx_pkg::OP_DIVW;

  // registered 32x32 product
  always_ff @(posedge clk) begin
    if (state == ppcx_pkg::S_EXEC) begin
      prod <= {32'd0, ra_q} * {32'd0,
              (it.func == ppcx_pkg::OP_MULLI) ? {{16{it.immediate[15]}}, it.immediate[15:0]}
                                              : rb_q};
    end
  end

  // divider operands as magnitudes
  always_comb begin
    dreq.go = (state == ppcx_pkg::S_EXEC) && div_op;
    dreq.dividend = (it.func == ppcx_pkg::OP_DIVW && ra_q[31]) ? -ra_q : ra_q;
    dreq.divisor = (it.func == ppcx_pkg::OP_DIVW && rb_q[31]) ? -rb_q : rb_q;
  end

  ppcx_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // control sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppcx_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ppcx_pkg::S_IDLE: if (accept) state_next = ppcx_pkg::S_READ;
      ppcx_pkg::S_READ: state_next = ppcx_pkg::S_EXEC;
      ppcx_pkg::S_EXEC: begin
        if (mul_op) state_next = ppcx_pkg::S_MUL;
        else if (div_op) state_next = ppcx_pkg::S_DIV;
        else state_next = ppcx_pkg::S_DONE;
      end
      ppcx_pkg::S_MUL: state_next = ppcx_pkg::S_DONE;
      ppcx_pkg::S_DIV: if (drsp.done) state_next = ppcx_pkg::S_DONE;
      ppcx_pkg::S_DONE: state_next = accept ? ppcx_pkg::S_READ : ppcx_pkg::S_IDLE;
      default: state_next = ppcx_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy = !(state == ppcx_pkg::S_IDLE || state == ppcx_pkg::S_DONE);
  end

  // operation logic, evaluated in the DONE cycle from held operands
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] simm;
  logic [31:0] uimm;
  logic [32:0] sum;
  logic [31:0] add_x;
  logic [31:0] add_y;
  logic        add_c;
  logic        use_add;
  logic [31:0] mhi;
  logic [31:0] q;
  logic [5:0]  shn;
  logic [31:0] sra_v;
  logic        sra_c;
  logic        slt_ab;
  logic        slt_ba;
  logic        s_lt;
  logic        s_gt;

  assign a = ra_q;
  assign b = rb_q;
  assign simm = {{16{it.immediate[15]}}, it.immediate[15:0]};
  assign uimm = {16'd0, it.immediate[15:0]};

  // shared adder operands
  always_comb begin
    use_add = 1'b1;
    add_x = a;
    add_y = b;
    add_c = 1'b0;
    case (it.func)
      ppcx_pkg::OP_ADDC, ppcx_pkg::OP_ADD: ;
      ppcx_pkg::OP_ADDE: add_c = carry_flag;
      ppcx_pkg::OP_ADDIC, ppcx_pkg::OP_ADDICR: add_y = simm;
      ppcx_pkg::OP_ADDI: begin add_x = (it.src_a_reg == 5'd0) ? '0 : a; add_y = simm; end
      ppcx_pkg::OP_ADDIS: begin
        add_x = (it.src_a_reg == 5'd0) ? '0 : a;
        add_y = {it.immediate[15:0], 16'd0};
      end
      ppcx_pkg::OP_ADDME: begin add_y = ppcx_pkg::ALL_ONES; add_c = carry_flag; end
      ppcx_pkg::OP_ADDZE: begin add_y = '0; add_c = carry_flag; end
      ppcx_pkg::OP_SUBFC, ppcx_pkg::OP_SUBF: begin add_x = ~a; add_c = 1'b1; end
      ppcx_pkg::OP_SUBFE: begin add_x = ~a; add_c = carry_flag; end
      ppcx_pkg::OP_SUBFIC: begin add_x = ~a; add_y = simm; add_c = 1'b1; end
      ppcx_pkg::OP_SUBFME: begin
        add_x = ~a; add_y = ppcx_pkg::ALL_ONES; add_c = carry_flag;
      end
      ppcx_pkg::OP_SUBFZE: begin add_x = ~a; add_y = '0; add_c = carry_flag; end
      ppcx_pkg::OP_NEG: begin add_x = ~a; add_y = '0; add_c = 1'b1; end
      default: use_add = 1'b0;
    endcase
  end
  assign sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_c};

  // signed high product correction and signed quotient
  assign mhi = prod[63:32] - (a[31] ? b : '0) - (b[31] ? a : '0);
  assign q = (it.func == ppcx_pkg::OP_DIVW && (a[31] ^ b[31])) ? -drsp.quotient
                                                                : drsp.quotient;

  // arithmetic shift right with carry when one-bits leave a negative source
  assign shn = (it.func == ppcx_pkg::OP_SRAWI) ? {1'b0, it.shift_amount} : b[5:0];
  always_comb begin
    if (shn[5]) begin
      sra_v = a[31] ? ppcx_pkg::ALL_ONES : '0;
      sra_c = a[31];
    end else begin
      sra_v = 32'($signed(a) >>> shn[4:0]);
      sra_c = a[31] && ((a & ~(ppcx_pkg::ALL_ONES << shn[4:0])) != '0);
    end
  end

  // compare and trap operand
  logic [31:0] cb;
  assign cb = (it.func == ppcx_pkg::OP_CMPI || it.func == ppcx_pkg::OP_TWI) ? simm :
              (it.func == ppcx_pkg::OP_CMPLI) ? uimm : b;
  assign slt_ab = $signed(a) < $signed(cb);
  assign slt_ba = $signed(cb) < $signed(a);
  assign s_lt = (it.func == ppcx_pkg::OP_CMPL || it.func == ppcx_pkg::OP_CMPLI) ? a < cb : slt_ab;
  assign s_gt = (it.func == ppcx_pkg::OP_CMPL || it.func == ppcx_pkg::OP_CMPLI) ? a > cb : slt_ba;

  // result selection
  always_comb begin
    val = sum[31:0];
    nca = carry_flag;
    wr = 1'b1;
    rec = it.record;
    cmpw = 1'b0;
    rdv = 1'b0;
    oechk = 1'b0;
    trap = 1'b0;
    crv = (s_lt ? ppcx_pkg::CR_LT : s_gt ? ppcx_pkg::CR_GT : ppcx_pkg::CR_EQ)
          | {3'd0, summary_overflow};
    case (it.func)
      ppcx_pkg::OP_ADDC, ppcx_pkg::OP_ADDE, ppcx_pkg::OP_ADDME, ppcx_pkg::OP_ADDZE,
      ppcx_pkg::OP_SUBFC, ppcx_pkg::OP_SUBFE, ppcx_pkg::OP_SUBFME, ppcx_pkg::OP_SUBFZE: begin
        nca = sum[32]; oechk = 1'b1;
      end
      ppcx_pkg::OP_ADD, ppcx_pkg::OP_SUBF: oechk = 1'b1;
      ppcx_pkg::OP_ADDI, ppcx_pkg::OP_ADDIS: rec = 1'b0;
      ppcx_pkg::OP_ADDIC, ppcx_pkg::OP_SUBFIC: begin nca = sum[32]; rec = 1'b0; end
      ppcx_pkg::OP_ADDICR: begin nca = sum[32]; rec = 1'b1; end
      ppcx_pkg::OP_NEG: oechk = (sum[31:0] == ppcx_pkg::SIGN_BIT);
      ppcx_pkg::OP_ANDC: val = a & ~b;
      ppcx_pkg::OP_ANDIR: begin val = a & uimm; rec = 1'b1; end
      ppcx_pkg::OP_ANDISR: begin val = a & {it.immediate[15:0], 16'd0}; rec = 1'b1; end
      ppcx_pkg::OP_AND: val = a & b;
      ppcx_pkg::OP_CMP, ppcx_pkg::OP_CMPI, ppcx_pkg::OP_CMPL, ppcx_pkg::OP_CMPLI: begin
        wr = 1'b0; cmpw = 1'b1; rec = 1'b0;
      end
      ppcx_pkg::OP_CNTLZW: val = {26'd0, ppcx_pkg::clz(a)};
      ppcx_pkg::OP_DIVWU: begin
        if (b == '0) begin oechk = 1'b1; val = '0; end
        else val = q;
      end
      ppcx_pkg::OP_DIVW: begin
        if (b == '0 || (a == ppcx_pkg::SIGN_BIT && b == ppcx_pkg::ALL_ONES)) begin
          oechk = 1'b1;
          val = (a[31] && b == '0) ? ppcx_pkg::ALL_ONES : '0;
        end else val = q;
      end
      ppcx_pkg::OP_EQV: val = ~(a ^ b);
      ppcx_pkg::OP_EXTSB: val = {{24{a[7]}}, a[7:0]};
      ppcx_pkg::OP_EXTSH: val = {{16{a[15]}}, a[15:0]};
      ppcx_pkg::OP_MULHWU: val = prod[63:32];
      ppcx_pkg::OP_MULHW: val = mhi;
      ppcx_pkg::OP_MULLI: begin val = prod[31:0]; rec = 1'b0; end
      ppcx_pkg::OP_MULLW: begin val = prod[31:0]; oechk = 1'b1; end
      ppcx_pkg::OP_NAND: val = ~(a & b);
      ppcx_pkg::OP_NOR: val = ~(a | b);
      ppcx_pkg::OP_ORC: val = a | ~b;
      ppcx_pkg::OP_ORI: begin val = a | uimm; rec = 1'b0; end
      ppcx_pkg::OP_ORIS: begin val = a | {it.immediate[15:0], 16'd0}; rec = 1'b0; end
      ppcx_pkg::OP_OR: val = a | b;
      ppcx_pkg::OP_RLWIMI: val = (rdo_q & ~ppcx_pkg::rot_mask(it.mask_begin, it.mask_end))
          | (ppcx_pkg::rotl(a, it.shift_amount) & ppcx_pkg::rot_mask(it.mask_begin, it.mask_end));
      ppcx_pkg::OP_RLWINM:
        val = ppcx_pkg::rotl(a, it.shift_amount) & ppcx_pkg::rot_mask(it.mask_begin, it.mask_end);
      ppcx_pkg::OP_RLWNM:
        val = ppcx_pkg::rotl(a, b[4:0]) & ppcx_pkg::rot_mask(it.mask_begin, it.mask_end);
      ppcx_pkg::OP_SLW: val = b[5] ? '0 : (a << b[4:0]);
      ppcx_pkg::OP_SRW: val = b[5] ? '0 : (a >> b[4:0]);
      ppcx_pkg::OP_SRAWI, ppcx_pkg::OP_SRAW: begin val = sra_v; nca = sra_c; end
      ppcx_pkg::OP_TW, ppcx_pkg::OP_TWI: begin
        wr = 1'b0; rec = 1'b0;
        trap = (slt_ab && it.trap_cond[4]) || (slt_ba && it.trap_cond[3]) ||
               (a == cb && it.trap_cond[2]) || (a < cb && it.trap_cond[1]) ||
               (a > cb && it.trap_cond[0]);
      end
      ppcx_pkg::OP_XORI: begin val = a ^ uimm; rec = 1'b0; end
      ppcx_pkg::OP_XORIS: begin val = a ^ {it.immediate[15:0], 16'd0}; rec = 1'b0; end
      ppcx_pkg::OP_XOR: val = a ^ b;
      ppcx_pkg::OP_WRITE: begin val = it.immediate; rec = 1'b0; end
      ppcx_pkg::OP_READ: begin wr = 1'b0; rec = 1'b0; rdv = 1'b1; val = rdo_q; end
      default: begin wr = 1'b0; rec = 1'b0; if (use_add) val = sum[31:0]; end
    endcase
  end

  // outcome of the done cycle
  logic blocked;
  logic fire;
  assign fire = state == ppcx_pkg::S_DONE;
  assign blocked = (oechk && it.overflow_enable) || trap;
  assign we = fire && wr && !blocked;
  assign wdata = val;

  // carry flag update
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_flag <= 1'b0;
    end else if (we) begin
      carry_flag <= nca;
    end
  end

  // result ports for the done cycle
  always_comb begin
    done = fire;
    dest_index = '0;
    result_value = '0;
    result_written = 1'b0;
    cr_field = '0;
    cr_value = '0;
    cr_written = 1'b0;
    carry_out = carry_flag;
    status = ppcx_pkg::ST_OK;
    if (oechk && it.overflow_enable) begin
      status = ppcx_pkg::ST_OE_UNSUP;
    end else if (trap) begin
      status = ppcx_pkg::ST_TRAP;
    end else if (wr) begin
      dest_index = it.dst_reg;
      result_value = val;
      result_written = 1'b1;
      carry_out = nca;
      if (rec) begin
        cr_value = (val == '0 ? ppcx_pkg::CR_EQ : val[31] ? ppcx_pkg::CR_LT : ppcx_pkg::CR_GT)
                   | {3'd0, summary_overflow};
        cr_written = 1'b1;
      end
    end else if (rdv) begin
      dest_index = it.dst_reg;
      result_value = val;
    end else if (cmpw) begin
      cr_field = it.cr_index;
      cr_value = crv;
      cr_written = 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !accept) else $error("item accepted while busy");
  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done && !start |=> !done) else $error("result strobe longer than one cycle");
  a_no_write_on_block: assert property (@(posedge clk) disable iff (rst)
    done && status != ppcx_pkg::ST_OK |-> !result_written && !cr_written)
    else $error("state updated on trap or unsupported overflow");
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> state == ppcx_pkg::S_DIV) else $error("divider finished out of sequence");
`endif

endmodule

FILE: sim/ppc32_integer_execute_unit_checker.sv
// result checker for the integer execute unit: watches both channels and predicts
`timescale 1ns / 100ps
module ppc32_integer_execute_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [5:0]  func,
  input  logic [4:0]  dst_reg,
  input  logic [4:0]  src_a_reg,
  input  logic [4:0]  src_b_reg,
  input  logic [31:0] immediate,
  input  logic [4:0]  shift_amount,
  input  logic [4:0]  mask_begin,
  input  logic [4:0]  mask_end,
  input  logic [4:0]  trap_cond,
  input  logic [2:0]  cr_index,
  input  logic        record,
  input  logic        overflow_enable,
  input  logic        done,
  input  logic [4:0]  dest_index,
  input  logic [31:0] result_value,
  input  logic        result_written,
  input  logic [2:0]  cr_field,
  input  logic [3:0]  cr_value,
  input  logic        cr_written,
  input  logic        carry_out,
  input  logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          outstanding,
  output int          results_seen
);

  typedef struct {
    logic [4:0]  dest;
    logic [31:0] value;
    logic        written;
    logic [2:0]  crf;
    logic [3:0]  crv;
    logic        crw;
    logic        carry;
    logic [1:0]  stat;
  } exec_result_t;

  localparam logic [1:0] ADDR_SUMMARY_OVERFLOW = 2'd0;

  logic [31:0]  gpr [32];
  logic         xer_ca;
  logic         so_bit;
  exec_result_t pending_results [$];

  // 33-bit sum of three words
  function automatic logic [32:0] sum3(input logic [31:0] x, y, z);
    sum3 = {1'b0, x} + {1'b0, y} + {1'b0, z};
  endfunction

  function automatic logic lt_signed(input logic [31:0] x, y);
    lt_signed = $signed(x) < $signed(y);
  endfunction

  function automatic logic [31:0] rotate_left(input logic [31:0] v, input logic [4:0] n);
    rotate_left = (n == 0) ? v : ((v << n) | (v >> (6'd32 - n)));
  endfunction

  // mask bit positions counted from the msb, wrapping when end is below begin
  function automatic logic [31:0] wrap_mask(input logic [4:0] mb, me);
    logic [31:0] m;
    m = '0;
    for (int i = 0; i < 32; i++) begin
      if (mb <= me) m[31-i] = (i >= mb) && (i <= me);
      else m[31-i] = (i >= mb) || (i <= me);
    end
    wrap_mask = m;
  endfunction

  function automatic logic [31:0] leading_zeros(input logic [31:0] v);
    int n;
    n = 0;
    while (n < 32 && !v[31-n]) n++;
    leading_zeros = 32'(n);
  endfunction

  // arithmetic shift right; carry only for a negative source losing one-bits
  function automatic logic [31:0] shift_arith(input logic [31:0] v, input logic [5:0] n,
                                              output logic co);
    logic [31:0] lost;
    if (n == 0) begin
      co = 1'b0;
      return v;
    end
    if (n >= 32) begin
      co = v[31];
      return v[31] ? ppcx_pkg::ALL_ONES : 32'd0;
    end
    lost = v & ~(ppcx_pkg::ALL_ONES << n);
    co = v[31] && (lost != 0);
    return $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic trap_hit(input logic [31:0] x, y, input logic [4:0] to);
    trap_hit = (lt_signed(x, y) && to[4]) || (lt_signed(y, x) && to[3]) ||
               (x == y && to[2]) || (x < y && to[1]) || (x > y && to[0]);
  endfunction

  function automatic logic [3:0] cr_from_value(input logic [31:0] v);
    cr_from_value = ((v == 0) ? ppcx_pkg::CR_EQ : (v[31] ? ppcx_pkg::CR_LT : ppcx_pkg::CR_GT))
                    | {3'b0, so_bit};
  endfunction

  function automatic logic [3:0] cr_from_compare(input logic lt, gt);
    cr_from_compare = (lt ? ppcx_pkg::CR_LT : (gt ? ppcx_pkg::CR_GT : ppcx_pkg::CR_EQ))
                      | {3'b0, so_bit};
  endfunction

  // executes one instruction on the shadow state and returns its outcome
  function automatic exec_result_t execute(input logic [5:0] f, input logic [4:0] d, a, b,
                                           input logic [31:0] imm, input logic [4:0] sh,
                                           mb, me, to, input logic [2:0] crx,
                                           input logic rec_in, oe);
    exec_result_t r;
    logic [31:0] ra, rb, rdo, simm, uimm, val, ma, mbv, m;
    logic [32:0] s;
    logic [63:0] prod;
    logic [3:0]  crv;
    logic        ca, nca, rec, wr, cmpw, oechk, trap, rd;
    ra = gpr[a]; rb = gpr[b]; rdo = gpr[d];
    ca = xer_ca; nca = xer_ca;
    simm = {{16{imm[15]}}, imm[15:0]};
    uimm = {16'd0, imm[15:0]};
    val = 0; crv = 0; rec = rec_in;
    wr = 1; cmpw = 0; oechk = 0; trap = 0; rd = 0;
    case (ppcx_pkg::op_t'(f))
      ppcx_pkg::OP_ADDC: begin
        s = sum3(ra, rb, 0); val = s[31:0]; nca = s[32]; oechk = 1;
      end
      ppcx_pkg::OP_ADDE: begin
        s = sum3(ra, rb, ca); val = s[31:0]; nca = s[32]; oechk = 1;
      end
      ppcx_pkg::OP_ADDI:   begin val = (a != 0 ? ra : 0) + simm; rec = 0; end
      ppcx_pkg::OP_ADDIC:  begin s = sum3(ra, simm, 0); val = s[31:0]; nca = s[32]; rec = 0; end
      ppcx_pkg::OP_ADDICR: begin s = sum3(ra, simm, 0); val = s[31:0]; nca = s[32]; rec = 1; end
      ppcx_pkg::OP_ADDIS:  begin val = (a != 0 ? ra : 0) + (simm << 16); rec = 0; end
      ppcx_pkg::OP_ADDME: begin
        s = sum3(ra, ca, ppcx_pkg::ALL_ONES); val = s[31:0]; nca = s[32]; oechk = 1;
      end
      ppcx_pkg::OP_ADD:    begin val = ra + rb; oechk = 1; end
      ppcx_pkg::OP_ADDZE: begin
        s = sum3(ra, ca, 0); val = s[31:0]; nca = s[32]; oechk = 1;
      end
      ppcx_pkg::OP_ANDC:   val = ra & ~rb;
      ppcx_pkg::OP_ANDIR:  begin val = ra & uimm; rec = 1; end
      ppcx_pkg::OP_ANDISR: begin val = ra & (uimm << 16); rec = 1; end
      ppcx_pkg::OP_AND:    val = ra & rb;
      ppcx_pkg::OP_CMP:    begin
        wr = 0; cmpw = 1; crv = cr_from_compare(lt_signed(ra, rb), lt_signed(rb, ra));
      end
      ppcx_pkg::OP_CMPI:   begin
        wr = 0; cmpw = 1; crv = cr_from_compare(lt_signed(ra, simm), lt_signed(simm, ra));
      end
      ppcx_pkg::OP_CMPL:   begin wr = 0; cmpw = 1; crv = cr_from_compare(ra < rb, ra > rb); end
      ppcx_pkg::OP_CMPLI:  begin
        wr = 0; cmpw = 1; crv = cr_from_compare(ra < uimm, ra > uimm);
      end
      ppcx_pkg::OP_CNTLZW: val = leading_zeros(ra);
      ppcx_pkg::OP_DIVWU:  begin
        if (rb == 0) begin oechk = 1; val = 0; end
        else val = ra / rb;
      end
      ppcx_pkg::OP_DIVW:   begin
        if (rb == 0 || (ra == ppcx_pkg::SIGN_BIT && rb == ppcx_pkg::ALL_ONES)) begin
          oechk = 1;
          val = (ra[31] && rb == 0) ? ppcx_pkg::ALL_ONES : 0;
        end else begin
          ma = ra[31] ? -ra : ra;
          mbv = rb[31] ? -rb : rb;
          val = ma / mbv;
          if (ra[31] ^ rb[31]) val = -val;
        end
      end
      ppcx_pkg::OP_EQV:    val = ~(ra ^ rb);
      ppcx_pkg::OP_EXTSB:  val = {{24{ra[7]}}, ra[7:0]};
      ppcx_pkg::OP_EXTSH:  val = {{16{ra[15]}}, ra[15:0]};
      ppcx_pkg::OP_MULHWU: begin prod = {32'd0, ra} * {32'd0, rb}; val = prod[63:32]; end
      ppcx_pkg::OP_MULHW:  begin
        prod = $signed({{32{ra[31]}}, ra}) * $signed({{32{rb[31]}}, rb});
        val = prod[63:32];
      end
      ppcx_pkg::OP_MULLI:  begin val = ra * simm; rec = 0; end
      ppcx_pkg::OP_MULLW:  begin val = ra * rb; oechk = 1; end
      ppcx_pkg::OP_NAND:   val = ~(ra & rb);
      ppcx_pkg::OP_NEG:    begin val = -ra; oechk = (val == ppcx_pkg::SIGN_BIT); end
      ppcx_pkg::OP_NOR:    val = ~(ra | rb);
      ppcx_pkg::OP_ORC:    val = ra | ~rb;
      ppcx_pkg::OP_ORI:    begin val = ra | uimm; rec = 0; end
      ppcx_pkg::OP_ORIS:   begin val = ra | (uimm << 16); rec = 0; end
      ppcx_pkg::OP_OR:     val = ra | rb;
      ppcx_pkg::OP_RLWIMI: begin
        m = wrap_mask(mb, me); val = (rdo & ~m) | (rotate_left(ra, sh) & m);
      end
      ppcx_pkg::OP_RLWINM: val = rotate_left(ra, sh) & wrap_mask(mb, me);
      ppcx_pkg::OP_RLWNM:  val = rotate_left(ra, rb[4:0]) & wrap_mask(mb, me);
      ppcx_pkg::OP_SLW:    val = rb[5] ? 0 : (ra << rb[4:0]);
      ppcx_pkg::OP_SRAWI:  val = shift_arith(ra, {1'b0, sh}, nca);
      ppcx_pkg::OP_SRAW:   val = shift_arith(ra, rb[5:0], nca);
      ppcx_pkg::OP_SRW:    val = rb[5] ? 0 : (ra >> rb[4:0]);
      ppcx_pkg::OP_SUBFC: begin
        s = sum3(~ra, rb, 1); val = s[31:0]; nca = s[32]; oechk = 1;
      end
      ppcx_pkg::OP_SUBFE: begin
        s = sum3(~ra, rb, ca); val = s[31:0]; nca = s[32]; oechk = 1;
      end
      ppcx_pkg::OP_SUBFIC: begin
        s = sum3(~ra, simm, 1); val = s[31:0]; nca = s[32]; rec = 0;
      end
      ppcx_pkg::OP_SUBFME: begin
        s = sum3(~ra, ca, ppcx_pkg::ALL_ONES); val = s[31:0]; nca = s[32]; oechk = 1;
      end
      ppcx_pkg::OP_SUBF:   begin val = rb - ra; oechk = 1; end
      ppcx_pkg::OP_SUBFZE: begin
        s = sum3(~ra, ca, 0); val = s[31:0]; nca = s[32]; oechk = 1;
      end
      ppcx_pkg::OP_TW:     begin wr = 0; rec = 0; trap = trap_hit(ra, rb, to); end
      ppcx_pkg::OP_TWI:    begin wr = 0; rec = 0; trap = trap_hit(ra, simm, to); end
      ppcx_pkg::OP_XORI:   begin val = ra ^ uimm; rec = 0; end
      ppcx_pkg::OP_XORIS:  begin val = ra ^ (uimm << 16); rec = 0; end
      ppcx_pkg::OP_XOR:    val = ra ^ rb;
      ppcx_pkg::OP_WRITE:  begin val = imm; rec = 0; end
      ppcx_pkg::OP_READ:   begin wr = 0; rec = 0; rd = 1; val = rdo; end
      default:             begin wr = 0; rec = 0; end
    endcase
    r = '{dest: 0, value: 0, written: 0, crf: 0, crv: 0, crw: 0, carry: ca,
          stat: ppcx_pkg::ST_OK};
    if (oechk && oe) begin
      r.stat = ppcx_pkg::ST_OE_UNSUP;
      return r;
    end
    if (trap) begin
      r.stat = ppcx_pkg::ST_TRAP;
      return r;
    end
    if (wr) begin
      gpr[d] = val;
      xer_ca = nca;
      r.dest = d; r.value = val; r.written = 1;
      if (rec) begin r.crf = 0; r.crv = cr_from_value(val); r.crw = 1; end
    end else if (rd) begin
      r.dest = d; r.value = val;
    end else if (cmpw) begin
      r.crf = crx; r.crv = crv; r.crw = 1;
    end
    r.carry = xer_ca;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp, act);
    if (exp !== act) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
      fail_count++;
    end
  endtask

  // result check first, then the prediction for a transfer on the same edge
  always @(posedge clk) begin
    exec_result_t e;
    if (rst) begin
      foreach (gpr[i]) gpr[i] = 0;
      xer_ca = 0;
      so_bit = 0;
      pending_results.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (done) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result strobe with no transfer outstanding");
          fail_count++;
        end else begin
          e = pending_results.pop_front();
          check_field("dest_index", e.dest, dest_index);
          check_field("result_value", e.value, result_value);
          check_field("result_written", e.written, result_written);
          check_field("cr_field", e.crf, cr_field);
          check_field("cr_value", e.crv, cr_value);
          check_field("cr_written", e.crw, cr_written);
          check_field("carry_out", e.carry, carry_out);
          check_field("status", e.stat, status);
        end
      end
      if (start && !busy)
        pending_results.push_back(execute(func, dst_reg, src_a_reg, src_b_reg, immediate,
                                          shift_amount, mask_begin, mask_end, trap_cond,
                                          cr_index, record, overflow_enable));
      if (psel && penable && pwrite && pready && paddr == ADDR_SUMMARY_OVERFLOW)
        so_bit = pwdata[0];
    end
    outstanding = pending_results.size();
  end

endmodule

FILE: sim/ppc32_integer_execute_unit_tb.sv
// stimulus and verdict for the integer execute unit testbench
`timescale 1ns / 100ps
module ppc32_integer_execute_unit_tb;

  localparam int RANDOM_ITEMS = 800;
  localparam int PHASES = 4;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [5:0]  func;
  logic [4:0]  dst_reg, src_a_reg, src_b_reg;
  logic [31:0] immediate;
  logic [4:0]  shift_amount, mask_begin, mask_end, trap_cond;
  logic [2:0]  cr_index;
  logic        record, overflow_enable;
  logic        done;
  logic [4:0]  dest_index;
  logic [31:0] result_value;
  logic        result_written;
  logic [2:0]  cr_field;
  logic [3:0]  cr_value;
  logic        cr_written, carry_out;
  logic [1:0]  status;
  logic        psel, penable, pwrite, pready;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, outstanding, results_seen;
  int          burst_left;
  int          items_sent;

  ppc32_integer_execute_unit u_dut (.*);

  ppc32_integer_execute_unit_checker u_checker (.*);

  // clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // hard limit on run time
  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

  // one command transfer, with random gaps between bursts
  task automatic send_item(input logic [5:0] f, input logic [4:0] d, a, b,
                           input logic [31:0] imm, input logic [4:0] sh, mb, me, to,
                           input logic [2:0] crx, input logic rec, oe);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    func <= f; dst_reg <= d; src_a_reg <= a; src_b_reg <= b; immediate <= imm;
    shift_amount <= sh; mask_begin <= mb; mask_end <= me; trap_cond <= to;
    cr_index <= crx; record <= rec; overflow_enable <= oe;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // simple form for register-to-register operations
  task automatic send_rr(input ppcx_pkg::op_t op, input logic [4:0] d, a, b,
                         input logic rec, oe);
    send_item(op, d, a, b, $urandom, 5'($urandom), 5'($urandom), 5'($urandom),
              5'($urandom), 3'($urandom), rec, oe);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: pick_word = 32'd0;
      1: pick_word = ppcx_pkg::ALL_ONES;
      2: pick_word = ppcx_pkg::SIGN_BIT;
      3: pick_word = 32'h7FFF_FFFF;
      4: pick_word = $urandom_range(0, 70);
      5: pick_word = -$urandom_range(1, 70);
      default: pick_word = $urandom;
    endcase
  endfunction

  // mostly real instructions on a small register pool, some register loads and junk codes
  task automatic send_random();
    logic [5:0] f;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 18) f = ppcx_pkg::OP_WRITE;
    else if (sel < 21) f = 6'($urandom_range(54, 63));
    else if (sel < 26) f = ppcx_pkg::OP_READ;
    else begin
      f = 6'($urandom_range(0, 51));
      // divides are slow, so keep them thin
      if ((f == ppcx_pkg::OP_DIVW || f == ppcx_pkg::OP_DIVWU) && $urandom_range(0, 2) != 0)
        f = 6'($urandom_range(0, 17));
    end
    send_item(f, 5'($urandom_range(0, 7)),
              ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom_range(0, 7)),
              5'($urandom_range(0, 7)), ($urandom_range(0, 1) == 0) ? pick_word() : $urandom,
              5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom), 3'($urandom),
              1'($urandom_range(0, 1)), ($urandom_range(0, 4) == 0));
  endtask

  // configuration write through the apb port, only while the unit is idle
  task automatic write_summary_overflow(input logic v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 2'd0;
    pwdata <= {31'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    logic so_setting;
    rst = 1'b1;
    start = 0; func = 0; dst_reg = 0; src_a_reg = 0; src_b_reg = 0; immediate = 0;
    shift_amount = 0; mask_begin = 0; mask_end = 0; trap_cond = 0; cr_index = 0;
    record = 0; overflow_enable = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    burst_left = 0;
    items_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_summary_overflow(1'b1);

    // directed: operand extremes and the special cases
    send_item(ppcx_pkg::OP_WRITE, 1, 0, 0, ppcx_pkg::SIGN_BIT, 0, 0, 0, 0, 0, 0, 0);
    send_item(ppcx_pkg::OP_WRITE, 2, 0, 0, ppcx_pkg::ALL_ONES, 0, 0, 0, 0, 0, 0, 0);
    send_item(ppcx_pkg::OP_WRITE, 3, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
    send_item(ppcx_pkg::OP_WRITE, 4, 0, 0, 32'd40, 0, 0, 0, 0, 0, 0, 0);
    send_rr(ppcx_pkg::OP_DIVW, 5, 1, 2, 0, 1);
    send_rr(ppcx_pkg::OP_DIVW, 5, 1, 0, 1, 0);
    send_rr(ppcx_pkg::OP_DIVWU, 5, 3, 0, 1, 1);
    send_rr(ppcx_pkg::OP_NEG, 6, 1, 0, 1, 1);
    send_rr(ppcx_pkg::OP_NEG, 6, 1, 0, 1, 0);
    send_rr(ppcx_pkg::OP_SRAW, 7, 1, 4, 1, 0);
    send_rr(ppcx_pkg::OP_SRAW, 7, 2, 0, 0, 0);
    send_item(ppcx_pkg::OP_SRAWI, 8, 2, 0, 0, 5'd31, 0, 0, 0, 0, 1, 0);
    send_rr(ppcx_pkg::OP_SUBFME, 9, 0, 0, 1, 0);
    send_rr(ppcx_pkg::OP_ADDME, 9, 2, 0, 1, 0);
    send_rr(ppcx_pkg::OP_ADDE, 10, 2, 2, 1, 1);
    send_item(ppcx_pkg::OP_TW, 0, 1, 3, 0, 0, 0, 0, 5'd16, 0, 0, 0);
    send_item(ppcx_pkg::OP_TWI, 0, 3, 0, 32'h0000_8000, 0, 0, 0, 5'd1, 0, 0, 0);
    send_item(ppcx_pkg::OP_CMPI, 0, 1, 0, 32'h0000_FFFF, 0, 0, 0, 0, 3'd7, 0, 0);
    send_rr(ppcx_pkg::OP_CMPL, 0, 1, 3, 0, 0);
    send_item(ppcx_pkg::OP_RLWIMI, 3, 2, 0, 0, 5'd31, 5'd31, 5'd0, 0, 0, 1, 0);
    send_item(ppcx_pkg::OP_RLWINM, 11, 1, 0, 0, 5'd1, 5'd0, 5'd31, 0, 0, 1, 0);
    send_item(ppcx_pkg::OP_ADDIS, 12, 0, 0, 32'hFFFF_8000, 0, 0, 0, 0, 0, 1, 0);
    send_rr(ppcx_pkg::OP_MULHW, 13, 1, 2, 1, 0);
    send_item(6'd63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_rr(ppcx_pkg::OP_READ, 9, 0, 0, 0, 0);
    wait_idle();

    // random phases, each under its own summary overflow setting
    for (int p = 0; p < PHASES; p++) begin
      so_setting = p[0];
      write_summary_overflow(so_setting);
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) send_random();
      wait_idle();
    end

    $display("ran %0d instructions, %0d results, summary overflow set both ways",
             items_sent, results_seen);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
